// ----- rtl/dzcc_pkg.sv -----
package dzcc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int OFF_W    = 13;
  localparam int EXP_W    = 14;
  localparam int CNT_W    = 14;
  localparam int SUM_W    = 38;
  localparam int CFG_W    = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int QUO_W    = SAMPLE_W;
  localparam int STEP_W   = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] MAX_WINDOW = CNT_W'(8192);
  localparam logic [CNT_W-1:0] COUNT_MAX  = CNT_W'(8191);

  localparam logic [CFG_W-1:0] DEMEAN_LEAD_RST = CFG_W'(400);
  localparam logic [CFG_W-1:0] LEAD_RST        = CFG_W'(200);
  localparam logic [CFG_W-1:0] LAG_RST         = CFG_W'(20);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  typedef enum logic [1:0] {
    ST_WAITING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_NO_LEAD  = 2'd2,
    ST_GAP      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_DEMEAN_EN   = 2'd0,
    REG_DEMEAN_LEAD = 2'd1,
    REG_LEAD        = 2'd2,
    REG_LAG         = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_ADD_ACC,
    S_DIV_VEL,
    S_DIV_ACC,
    S_CROSS,
    S_DONE
  } fsm_t;

endpackage

// ----- rtl/demeaned_zero_crossing_counter_core.sv -----
// Channel  Handshake                          Item fields
// in_      in_valid / in_ready                operation, sample_offset, sample_vel, sample_acc
// out_     out_valid / out_ready              status, crossings_vel, crossings_acc, vel/acc means
// cfg_     cfg_psel, cfg_penable, cfg_pwrite  enable, demean lead, lead, lag at byte 4*i
//
// Items are taken one at a time; in_ready is high only while idle. Per item: update, add,
// then one shared serial divider forms both means at one quotient bit per cycle (24 steps
// each), then crossing and result load. One result per item. Reset (rst_n low, synchronous)
// clears the measurement and loads register defaults. The result sits in an output register;
// a stalled out_ready holds that result and stalls the next item at result load, in_ready low.
module demeaned_zero_crossing_counter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic signed [dzcc_pkg::OFF_W-1:0]     in_sample_offset,
  input  logic signed [dzcc_pkg::SAMPLE_W-1:0]  in_sample_vel,
  input  logic signed [dzcc_pkg::SAMPLE_W-1:0]  in_sample_acc,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [1:0]                     out_status,
  output logic signed [dzcc_pkg::CNT_W-1:0]     out_crossings_vel,
  output logic signed [dzcc_pkg::CNT_W-1:0]     out_crossings_acc,
  output logic signed [dzcc_pkg::SAMPLE_W-1:0]  out_mean_vel,
  output logic signed [dzcc_pkg::SAMPLE_W-1:0]  out_mean_acc,

  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic        [dzcc_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic        [dzcc_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic        [dzcc_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int SW = dzcc_pkg::SAMPLE_W;
  localparam int EW = dzcc_pkg::EXP_W;
  localparam int CW = dzcc_pkg::CFG_W;

  // configuration
  logic                   demean_en_r;
  logic [CW-1:0]          demean_lead_r;
  logic [CW-1:0]          lead_r;
  logic [CW-1:0]          lag_r;
  logic                   cfg_wr;
  dzcc_pkg::reg_idx_t     cfg_idx;

  // item latch
  logic                              op_r, op_nxt;
  logic signed [dzcc_pkg::OFF_W-1:0] off_r, off_nxt;
  logic signed [SW-1:0]              vel_r, vel_nxt;
  logic signed [SW-1:0]              acc_r, acc_nxt;

  // measurement state
  dzcc_pkg::fsm_t                    state_r, state_nxt;
  logic signed [EW-1:0]              expected_r, expected_nxt;
  logic                              any_taken_r, any_taken_nxt;
  logic [dzcc_pkg::CNT_W-1:0]        mean_count_r, mean_count_nxt;
  logic signed [dzcc_pkg::SUM_W-1:0] sum_vel_r, sum_vel_nxt;
  logic signed [dzcc_pkg::SUM_W-1:0] sum_acc_r, sum_acc_nxt;
  logic                              above_vel_r, above_vel_nxt;
  logic                              above_acc_r, above_acc_nxt;
  logic signed [dzcc_pkg::CNT_W-1:0] cnt_vel_r, cnt_vel_nxt;
  logic signed [dzcc_pkg::CNT_W-1:0] cnt_acc_r, cnt_acc_nxt;
  dzcc_pkg::status_t                 status_r, status_nxt;
  logic                              win_r, win_nxt;
  logic                              add_r, add_nxt;
  logic signed [SW-1:0]              mean_vel_r, mean_vel_nxt;
  logic signed [SW-1:0]              mean_acc_r, mean_acc_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r, out_status_nxt;
  logic signed [dzcc_pkg::CNT_W-1:0] out_cv_r, out_cv_nxt;
  logic signed [dzcc_pkg::CNT_W-1:0] out_ca_r, out_ca_nxt;
  logic signed [SW-1:0]              out_mv_r, out_mv_nxt;
  logic signed [SW-1:0]              out_ma_r, out_ma_nxt;

  // shared divider
  logic                              div_start;
  logic signed [dzcc_pkg::SUM_W-1:0] div_dividend;
  logic                              div_done;
  logic signed [SW-1:0]              div_quot;

  logic signed [EW-1:0] off_ext;
  logic signed [EW-1:0] dlead_neg;
  logic signed [EW-1:0] lead_neg;
  logic signed [EW-1:0] lag_s;
  logic                 use_mean;
  logic                 a_vel;
  logic                 a_acc;

  assign off_ext   = EW'(off_r);
  assign dlead_neg = -$signed({{(EW-CW){1'b0}}, demean_lead_r});
  assign lead_neg  = -$signed({{(EW-CW){1'b0}}, lead_r});
  assign lag_s     = $signed({{(EW-CW){1'b0}}, lag_r});
  assign use_mean  = demean_en_r && (mean_count_r != '0);
  assign a_vel     = (vel_r > mean_vel_r);
  assign a_acc     = (acc_r > mean_acc_r);

  assign div_dividend = (state_r == dzcc_pkg::S_ADD_ACC) ? sum_vel_r : sum_acc_r;

  dzcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (mean_count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = dzcc_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      dzcc_pkg::REG_DEMEAN_EN:   cfg_prdata = {{(dzcc_pkg::DATA_W-1){1'b0}}, demean_en_r};
      dzcc_pkg::REG_DEMEAN_LEAD: cfg_prdata = {{(dzcc_pkg::DATA_W-CW){1'b0}}, demean_lead_r};
      dzcc_pkg::REG_LEAD:        cfg_prdata = {{(dzcc_pkg::DATA_W-CW){1'b0}}, lead_r};
      dzcc_pkg::REG_LAG:         cfg_prdata = {{(dzcc_pkg::DATA_W-CW){1'b0}}, lag_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      demean_en_r   <= 1'b1;
      demean_lead_r <= dzcc_pkg::DEMEAN_LEAD_RST;
      lead_r        <= dzcc_pkg::LEAD_RST;
      lag_r         <= dzcc_pkg::LAG_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dzcc_pkg::REG_DEMEAN_EN:   demean_en_r   <= cfg_pwdata[0];
        dzcc_pkg::REG_DEMEAN_LEAD: demean_lead_r <= cfg_pwdata[CW-1:0];
        dzcc_pkg::REG_LEAD:        lead_r        <= cfg_pwdata[CW-1:0];
        dzcc_pkg::REG_LAG:         lag_r         <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    off_nxt        = off_r;
    vel_nxt        = vel_r;
    acc_nxt        = acc_r;
    expected_nxt   = expected_r;
    any_taken_nxt  = any_taken_r;
    mean_count_nxt = mean_count_r;
    sum_vel_nxt    = sum_vel_r;
    sum_acc_nxt    = sum_acc_r;
    above_vel_nxt  = above_vel_r;
    above_acc_nxt  = above_acc_r;
    cnt_vel_nxt    = cnt_vel_r;
    cnt_acc_nxt    = cnt_acc_r;
    status_nxt     = status_r;
    win_nxt        = win_r;
    add_nxt        = add_r;
    mean_vel_nxt   = mean_vel_r;
    mean_acc_nxt   = mean_acc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_cv_nxt     = out_cv_r;
    out_ca_nxt     = out_ca_r;
    out_mv_nxt     = out_mv_r;
    out_ma_nxt     = out_ma_r;
    in_ready       = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      dzcc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_operation;
          off_nxt   = in_sample_offset;
          vel_nxt   = in_sample_vel;
          acc_nxt   = in_sample_acc;
          state_nxt = dzcc_pkg::S_UPDATE;
        end
      end
      dzcc_pkg::S_UPDATE: begin
        win_nxt   = 1'b0;
        add_nxt   = 1'b0;
        state_nxt = dzcc_pkg::S_ADD_ACC;
        if (op_r == dzcc_pkg::OP_START) begin
          any_taken_nxt  = 1'b0;
          mean_count_nxt = '0;
          sum_vel_nxt    = '0;
          sum_acc_nxt    = '0;
          above_vel_nxt  = 1'b0;
          above_acc_nxt  = 1'b0;
          cnt_vel_nxt    = '1;
          cnt_acc_nxt    = '1;
          status_nxt     = dzcc_pkg::ST_WAITING;
          expected_nxt   = dlead_neg;
        end else if (status_r == dzcc_pkg::ST_WAITING && off_ext >= expected_r) begin
          if (off_ext > expected_r) begin
            status_nxt = any_taken_r ? dzcc_pkg::ST_GAP : dzcc_pkg::ST_NO_LEAD;
          end else begin
            any_taken_nxt = 1'b1;
            expected_nxt  = expected_r + 1'b1;
            if (demean_en_r && off_ext >= dlead_neg &&
                mean_count_r < dzcc_pkg::MAX_WINDOW) begin
              mean_count_nxt = mean_count_r + 1'b1;
              sum_vel_nxt    = sum_vel_r + dzcc_pkg::SUM_W'(vel_r);
              add_nxt        = 1'b1;
            end
            win_nxt = (off_ext >= lead_neg) && (off_ext <= lag_s);
            if (off_ext >= lag_s) begin
              status_nxt = dzcc_pkg::ST_COMPLETE;
            end
          end
        end
      end
      dzcc_pkg::S_ADD_ACC: begin
        if (add_r) begin
          sum_acc_nxt = sum_acc_r + dzcc_pkg::SUM_W'(acc_r);
        end
        div_start = 1'b1;
        state_nxt = dzcc_pkg::S_DIV_VEL;
      end
      dzcc_pkg::S_DIV_VEL: begin
        if (div_done) begin
          mean_vel_nxt = use_mean ? div_quot : '0;
          div_start    = 1'b1;
          state_nxt    = dzcc_pkg::S_DIV_ACC;
        end
      end
      dzcc_pkg::S_DIV_ACC: begin
        if (div_done) begin
          mean_acc_nxt = use_mean ? div_quot : '0;
          state_nxt    = dzcc_pkg::S_CROSS;
        end
      end
      dzcc_pkg::S_CROSS: begin
        if (win_r) begin
          if (cnt_vel_r[dzcc_pkg::CNT_W-1]) begin
            cnt_vel_nxt   = '0;
            above_vel_nxt = a_vel;
          end else if (a_vel != above_vel_r) begin
            above_vel_nxt = a_vel;
            if (cnt_vel_r < $signed(dzcc_pkg::COUNT_MAX)) begin
              cnt_vel_nxt = cnt_vel_r + 1'b1;
            end
          end
          if (cnt_acc_r[dzcc_pkg::CNT_W-1]) begin
            cnt_acc_nxt   = '0;
            above_acc_nxt = a_acc;
          end else if (a_acc != above_acc_r) begin
            above_acc_nxt = a_acc;
            if (cnt_acc_r < $signed(dzcc_pkg::COUNT_MAX)) begin
              cnt_acc_nxt = cnt_acc_r + 1'b1;
            end
          end
        end
        state_nxt = dzcc_pkg::S_DONE;
      end
      dzcc_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cv_nxt     = cnt_vel_r;
          out_ca_nxt     = cnt_acc_r;
          out_mv_nxt     = mean_vel_r;
          out_ma_nxt     = mean_acc_r;
          state_nxt      = dzcc_pkg::S_IDLE;
        end
      end
      default: state_nxt = dzcc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dzcc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= '0;
      any_taken_r  <= 1'b0;
      mean_count_r <= '0;
      sum_vel_r    <= '0;
      sum_acc_r    <= '0;
      above_vel_r  <= 1'b0;
      above_acc_r  <= 1'b0;
      cnt_vel_r    <= '1;
      cnt_acc_r    <= '1;
      status_r     <= dzcc_pkg::ST_WAITING;
      win_r        <= 1'b0;
      add_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      expected_r   <= expected_nxt;
      any_taken_r  <= any_taken_nxt;
      mean_count_r <= mean_count_nxt;
      sum_vel_r    <= sum_vel_nxt;
      sum_acc_r    <= sum_acc_nxt;
      above_vel_r  <= above_vel_nxt;
      above_acc_r  <= above_acc_nxt;
      cnt_vel_r    <= cnt_vel_nxt;
      cnt_acc_r    <= cnt_acc_nxt;
      status_r     <= status_nxt;
      win_r        <= win_nxt;
      add_r        <= add_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    off_r        <= off_nxt;
    vel_r        <= vel_nxt;
    acc_r        <= acc_nxt;
    mean_vel_r   <= mean_vel_nxt;
    mean_acc_r   <= mean_acc_nxt;
    out_status_r <= out_status_nxt;
    out_cv_r     <= out_cv_nxt;
    out_ca_r     <= out_ca_nxt;
    out_mv_r     <= out_mv_nxt;
    out_ma_r     <= out_ma_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_crossings_vel = out_cv_r;
  assign out_crossings_acc = out_ca_r;
  assign out_mean_vel      = out_mv_r;
  assign out_mean_acc      = out_ma_r;

endmodule

// ----- rtl/dzcc_div.sv -----
module dzcc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [dzcc_pkg::SUM_W-1:0]    dividend,
  input  logic        [dzcc_pkg::CNT_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [dzcc_pkg::QUO_W-1:0]    quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [dzcc_pkg::STEP_W-1:0]   step_r;
  logic                          neg_r;
  logic [dzcc_pkg::CNT_W-1:0]    rem_r;
  logic [dzcc_pkg::QUO_W-1:0]    lo_r;
  logic [dzcc_pkg::QUO_W-1:0]    q_r;

  logic [dzcc_pkg::SUM_W-1:0]    mag;
  logic [dzcc_pkg::CNT_W:0]      trial;
  logic [dzcc_pkg::CNT_W:0]      diff;
  logic                          ge;
  logic [dzcc_pkg::QUO_W:0]      q_ext;
  logic [dzcc_pkg::QUO_W:0]      q_floor;

  assign mag   = dividend[dzcc_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, lo_r[dzcc_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  assign q_ext   = {1'b0, q_r};
  assign q_floor = neg_r ? ((~q_ext + 1'b1) - {{dzcc_pkg::QUO_W{1'b0}}, (rem_r != '0)})
                         : q_ext;

  assign done     = done_r;
  assign quotient = q_floor[dzcc_pkg::QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == dzcc_pkg::STEP_W'(dzcc_pkg::QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[dzcc_pkg::SUM_W-1];
      rem_r <= mag[dzcc_pkg::SUM_W-1:dzcc_pkg::QUO_W];
      lo_r  <= mag[dzcc_pkg::QUO_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[dzcc_pkg::CNT_W-1:0] : trial[dzcc_pkg::CNT_W-1:0];
      lo_r  <= {lo_r[dzcc_pkg::QUO_W-2:0], 1'b0};
      q_r   <= {q_r[dzcc_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

// ----- test/tb_demeaned_zero_crossing_counter_core.sv -----
module tb_demeaned_zero_crossing_counter_core;

  localparam int ITEMS_TOTAL = 1050;
  localparam int DRAIN_CYCLES = 80;
  localparam logic signed [dzcc_pkg::SAMPLE_W-1:0] VMAX =
    {1'b0, {(dzcc_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [dzcc_pkg::SAMPLE_W-1:0] VMIN =
    {1'b1, {(dzcc_pkg::SAMPLE_W-1){1'b0}}};

  typedef struct {
    dzcc_pkg::status_t                     status;
    logic signed [dzcc_pkg::CNT_W-1:0]     cross_vel;
    logic signed [dzcc_pkg::CNT_W-1:0]     cross_acc;
    logic signed [dzcc_pkg::SAMPLE_W-1:0]  avg_vel;
    logic signed [dzcc_pkg::SAMPLE_W-1:0]  avg_acc;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  in_operation = dzcc_pkg::OP_SAMPLE;
  logic signed [dzcc_pkg::OFF_W-1:0]     in_sample_offset = '0;
  logic signed [dzcc_pkg::SAMPLE_W-1:0]  in_sample_vel = '0;
  logic signed [dzcc_pkg::SAMPLE_W-1:0]  in_sample_acc = '0;

  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [1:0]                            out_status;
  logic signed [dzcc_pkg::CNT_W-1:0]     out_crossings_vel;
  logic signed [dzcc_pkg::CNT_W-1:0]     out_crossings_acc;
  logic signed [dzcc_pkg::SAMPLE_W-1:0]  out_mean_vel;
  logic signed [dzcc_pkg::SAMPLE_W-1:0]  out_mean_acc;

  logic                                  cfg_psel = 1'b0;
  logic                                  cfg_penable = 1'b0;
  logic                                  cfg_pwrite = 1'b0;
  logic [dzcc_pkg::ADDR_W-1:0]           cfg_paddr = '0;
  logic [dzcc_pkg::DATA_W-1:0]           cfg_pwdata = '0;
  logic [dzcc_pkg::DATA_W-1:0]           cfg_prdata;
  logic                                  cfg_pready;

  demeaned_zero_crossing_counter_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample_offset  (in_sample_offset),
    .in_sample_vel     (in_sample_vel),
    .in_sample_acc     (in_sample_acc),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_crossings_vel (out_crossings_vel),
    .out_crossings_acc (out_crossings_acc),
    .out_mean_vel      (out_mean_vel),
    .out_mean_acc      (out_mean_acc),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #2 clk = ~clk;

  logic                                  demean_en_cfg;
  logic [dzcc_pkg::CFG_W-1:0]            demean_lead_cfg;
  logic [dzcc_pkg::CFG_W-1:0]            lead_cfg;
  logic [dzcc_pkg::CFG_W-1:0]            lag_cfg;

  logic signed [dzcc_pkg::EXP_W-1:0]     next_offset;
  bit                                    taken;
  logic [dzcc_pkg::CNT_W-1:0]            n_mean;
  logic signed [dzcc_pkg::SUM_W-1:0]     vel_sum;
  logic signed [dzcc_pkg::SUM_W-1:0]     acc_sum;
  bit                                    vel_above;
  bit                                    acc_above;
  logic signed [dzcc_pkg::CNT_W-1:0]     vel_cross;
  logic signed [dzcc_pkg::CNT_W-1:0]     acc_cross;
  dzcc_pkg::status_t                     meas_status;

  report_t predicted_reports[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  bit      steady = 1'b0;
  int      holdoff_req = 0;

  function automatic void clear_measurement();
    taken = 1'b0;
    n_mean = '0;
    vel_sum = '0;
    acc_sum = '0;
    vel_above = 1'b0;
    acc_above = 1'b0;
    vel_cross = '1;
    acc_cross = '1;
    meas_status = dzcc_pkg::ST_WAITING;
  endfunction

  function automatic void reset_model();
    demean_en_cfg = 1'b1;
    demean_lead_cfg = dzcc_pkg::DEMEAN_LEAD_RST;
    lead_cfg = dzcc_pkg::LEAD_RST;
    lag_cfg = dzcc_pkg::LAG_RST;
    next_offset = '0;
    clear_measurement();
  endfunction

  function automatic longint floor_mean(longint total, int count);
    longint q;
    if (count <= 0) return 0;
    q = total / count;
    if ((total % count) != 0 && total < 0) q = q - 1;
    return q;
  endfunction

  function automatic void tally(inout logic signed [dzcc_pkg::CNT_W-1:0] cnt,
                                inout bit above, input longint x, input longint level);
    bit a;
    a = x > level;
    if (cnt < 0) begin
      cnt = '0;
      above = a;
    end else if (a != above) begin
      above = a;
      if (cnt < $signed(dzcc_pkg::COUNT_MAX)) cnt = cnt + 1'b1;
    end
  endfunction

  function automatic report_t advance_measurement(logic op,
                                                  logic signed [dzcc_pkg::OFF_W-1:0] off,
                                                  logic signed [dzcc_pkg::SAMPLE_W-1:0] vel,
                                                  logic signed [dzcc_pkg::SAMPLE_W-1:0] acc);
    report_t r;
    longint  mv;
    longint  ma;
    int      o;
    o = int'(off);
    if (op == dzcc_pkg::OP_START) begin
      clear_measurement();
      next_offset = dzcc_pkg::EXP_W'(-int'(demean_lead_cfg));
    end else if (meas_status == dzcc_pkg::ST_WAITING && o >= int'(next_offset)) begin
      if (o > int'(next_offset)) begin
        meas_status = taken ? dzcc_pkg::ST_GAP : dzcc_pkg::ST_NO_LEAD;
      end else begin
        taken = 1'b1;
        next_offset = next_offset + 1'b1;
        if (demean_en_cfg && o >= -int'(demean_lead_cfg) && n_mean < dzcc_pkg::MAX_WINDOW) begin
          n_mean = n_mean + 1'b1;
          vel_sum = vel_sum + dzcc_pkg::SUM_W'(vel);
          acc_sum = acc_sum + dzcc_pkg::SUM_W'(acc);
        end
        mv = demean_en_cfg ? floor_mean(longint'(vel_sum), int'(n_mean)) : '0;
        ma = demean_en_cfg ? floor_mean(longint'(acc_sum), int'(n_mean)) : '0;
        if (o >= -int'(lead_cfg) && o <= int'(lag_cfg)) begin
          tally(vel_cross, vel_above, longint'(vel), mv);
          tally(acc_cross, acc_above, longint'(acc), ma);
        end
        if (o >= int'(lag_cfg)) meas_status = dzcc_pkg::ST_COMPLETE;
      end
    end
    mv = demean_en_cfg ? floor_mean(longint'(vel_sum), int'(n_mean)) : '0;
    ma = demean_en_cfg ? floor_mean(longint'(acc_sum), int'(n_mean)) : '0;
    r.status = meas_status;
    r.cross_vel = vel_cross;
    r.cross_acc = acc_cross;
    r.avg_vel = dzcc_pkg::SAMPLE_W'(mv);
    r.avg_acc = dzcc_pkg::SAMPLE_W'(ma);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (predicted_reports.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = predicted_reports.pop_front();
        check_field("status", 64'(out_status), 64'(want.status));
        check_field("crossings_vel", 64'(out_crossings_vel), 64'(want.cross_vel));
        check_field("crossings_acc", 64'(out_crossings_acc), 64'(want.cross_acc));
        check_field("mean_vel", 64'(out_mean_vel), 64'(want.avg_vel));
        check_field("mean_acc", 64'(out_mean_acc), 64'(want.avg_acc));
      end
      results_seen++;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req > 0) begin
        stall = holdoff_req;
        holdoff_req = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  function automatic int clamp_offset(int o);
    if (o < -4096) return -4096;
    if (o > 4095) return 4095;
    return o;
  endfunction

  function automatic int rand_offset();
    return int'($signed(dzcc_pkg::OFF_W'($urandom)));
  endfunction

  function automatic logic signed [dzcc_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return dzcc_pkg::SAMPLE_W'($urandom);
      1: return dzcc_pkg::SAMPLE_W'(int'($urandom_range(6)) - 3);
      2: return $urandom_range(1) ? VMAX : VMIN;
      default: return dzcc_pkg::SAMPLE_W'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic send_item(logic op, int off, logic signed [dzcc_pkg::SAMPLE_W-1:0] vel,
                           logic signed [dzcc_pkg::SAMPLE_W-1:0] acc);
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sample_offset <= dzcc_pkg::OFF_W'(off);
    in_sample_vel <= vel;
    in_sample_acc <= acc;
    do @(posedge clk); while (!in_ready);
    predicted_reports.push_back(advance_measurement(op, dzcc_pkg::OFF_W'(off), vel, acc));
    items_sent++;
  endtask

  task automatic send_sample(int off);
    send_item(dzcc_pkg::OP_SAMPLE, clamp_offset(off), pick_sample(), pick_sample());
  endtask

  task automatic send_start();
    send_item(dzcc_pkg::OP_START, rand_offset(), pick_sample(), pick_sample());
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(dzcc_pkg::reg_idx_t idx, logic [dzcc_pkg::CFG_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= dzcc_pkg::DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      dzcc_pkg::REG_DEMEAN_EN:   demean_en_cfg = val[0];
      dzcc_pkg::REG_DEMEAN_LEAD: demean_lead_cfg = val;
      dzcc_pkg::REG_LEAD:        lead_cfg = val;
      dzcc_pkg::REG_LAG:         lag_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, int dm_lead, int lead, int lag);
    write_reg(dzcc_pkg::REG_DEMEAN_EN, dzcc_pkg::CFG_W'(en));
    write_reg(dzcc_pkg::REG_DEMEAN_LEAD, dzcc_pkg::CFG_W'(dm_lead));
    write_reg(dzcc_pkg::REG_LEAD, dzcc_pkg::CFG_W'(lead));
    write_reg(dzcc_pkg::REG_LAG, dzcc_pkg::CFG_W'(lag));
  endtask

  task automatic random_config();
    int dl;
    int ld;
    int lg;
    dl = ($urandom_range(5) == 0) ? 0 : $urandom_range(12);
    ld = ($urandom_range(7) == 0) ? 4095 : $urandom_range(14);
    lg = ($urandom_range(5) == 0) ? 0 : $urandom_range(12);
    set_config($urandom_range(3) != 0, dl, ld, lg);
  endtask

  task automatic run_measurement();
    int kind;
    int first;
    int last;
    int cut;
    first = -int'(demean_lead_cfg);
    last = int'(lag_cfg);
    send_start();
    kind = $urandom_range(9);
    if (kind == 0) begin
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(1)) send_sample(rand_offset());
        else send_sample(first - 3 + int'($urandom_range(last - first + 6)));
      end
    end else begin
      cut = first + int'($urandom_range(last - first + 1));
      repeat ($urandom_range(2)) send_sample(first - 1 - int'($urandom_range(5)));
      for (int o = first; o <= last; o++) begin
        if (kind == 1 && o == cut) begin
          send_sample(o + 1 + int'($urandom_range(3)));
          break;
        end
        if ($urandom_range(19) == 0) send_sample(o - 1 - int'($urandom_range(2)));
        send_sample(o);
      end
      repeat ($urandom_range(2)) send_sample(rand_offset());
    end
  endtask

  task automatic test_no_start();
    send_sample(-4096);
    send_item(dzcc_pkg::OP_SAMPLE, 0, VMAX, VMIN);
    send_item(dzcc_pkg::OP_SAMPLE, 1, VMIN, VMAX);
    send_sample(3);
    send_sample(4);
  endtask

  task automatic test_no_lead();
    send_start();
    send_sample(4095);
  endtask

  task automatic test_mean_disabled();
    wait_drain();
    set_config(1'b0, 2, 1, 1);
    send_start();
    send_sample(-2);
    send_sample(-1);
    send_item(dzcc_pkg::OP_SAMPLE, 0, '0, '0);
    send_sample(1);
    send_sample(2);
  endtask

  task automatic test_wide_window();
    wait_drain();
    set_config(1'b1, 4095, 4095, 0);
    send_start();
    send_item(dzcc_pkg::OP_SAMPLE, -4095, VMIN, VMIN);
    send_item(dzcc_pkg::OP_SAMPLE, -4094, VMAX, VMAX);
    send_sample(-4096);
    wait_drain();
    write_reg(dzcc_pkg::REG_LEAD, '0);
    write_reg(dzcc_pkg::REG_DEMEAN_EN, '0);
    send_sample(-4093);
    send_sample(4095);
  endtask

  task automatic test_long_lag();
    wait_drain();
    set_config(1'b1, 0, 0, 4095);
    send_start();
    send_sample(0);
    send_sample(4095);
  endtask

  task automatic test_output_holdoff();
    wait_drain();
    set_config(1'b1, 3, 2, 4);
    steady = 1'b1;
    holdoff_req = 300;
    send_start();
    for (int o = -3; o <= 4; o++) send_sample(o);
    steady = 1'b0;
    wait_drain();
  endtask

  task automatic test_back_to_back();
    wait_drain();
    random_config();
    steady = 1'b1;
    repeat (6) run_measurement();
    steady = 1'b0;
  endtask

  task automatic test_random_measurements();
    while (items_sent < ITEMS_TOTAL) begin
      wait_drain();
      random_config();
      repeat ($urandom_range(3, 8)) run_measurement();
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_start();
    test_no_lead();
    test_mean_disabled();
    test_wide_window();
    test_long_lag();
    test_output_holdoff();
    test_back_to_back();
    test_random_measurements();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** demeaned_zero_crossing_counter_core: PASSED **");
    end else begin
      $display("** demeaned_zero_crossing_counter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** demeaned_zero_crossing_counter_core: FAILED **");
    $finish;
  end

endmodule

// ----- demeaned_zero_crossing_counter_core.f -----
rtl/dzcc_pkg.sv
rtl/dzcc_div.sv
rtl/demeaned_zero_crossing_counter_core.sv
test/tb_demeaned_zero_crossing_counter_core.sv
